[rtl/jsw_pkg.sv]
// Package for the JSON stream writer: payload types, event kind codes,
// character constants and the text body builder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsw_pkg;

   localparam logic [2:0] KIND_BEGIN_OBJ = 3'd0;
   localparam logic [2:0] KIND_END_OBJ   = 3'd1;
   localparam logic [2:0] KIND_BEGIN_ARR = 3'd2;
   localparam logic [2:0] KIND_END_ARR   = 3'd3;
   localparam logic [2:0] KIND_KEY       = 3'd4;
   localparam logic [2:0] KIND_STRING    = 3'd5;
   localparam logic [2:0] KIND_INT       = 3'd6;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;

   localparam int BODY_MAX = 10;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         text_byte;
      logic               text_first;
      logic               text_last;
      logic               text_empty;
      logic signed [63:0] int_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
      logic       out_error;
   } rsp_payload_type;

   typedef struct packed {
      logic [BODY_MAX-1:0][7:0] chars;
      logic [3:0]               len;
   } body_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
   endfunction

   // Bracket or quoted/escaped text that follows any separator and indent.
   function automatic body_type build_body(input logic [2:0] kind,
                                           input logic [7:0] tb,
                                           input logic       first,
                                           input logic       last,
                                           input logic       empty);
      body_type   b;
      logic [3:0] n;
      b.chars = '0;
      n       = 4'd0;
      case (kind)
         KIND_BEGIN_OBJ: begin b.chars[0] = CH_LBRACE; n = 4'd1; end
         KIND_BEGIN_ARR: begin b.chars[0] = CH_LBRACK; n = 4'd1; end
         KIND_END_OBJ:   begin b.chars[0] = CH_RBRACE; n = 4'd1; end
         KIND_END_ARR:   begin b.chars[0] = CH_RBRACK; n = 4'd1; end
         KIND_KEY, KIND_STRING: begin
            if (first || empty) begin
               b.chars[n] = CH_QUOTE; n = n + 4'd1;
            end
            if (!empty) begin
               case (tb)
                  8'h22: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h22; n = n + 4'd2; end
                  8'h5c: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h5c; n = n + 4'd2; end
                  8'h0a: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h6e; n = n + 4'd2; end
                  8'h0d: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h72; n = n + 4'd2; end
                  8'h09: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h74; n = n + 4'd2; end
                  8'h08: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h62; n = n + 4'd2; end
                  8'h0c: begin b.chars[n] = CH_BSLASH; b.chars[n+4'd1] = 8'h66; n = n + 4'd2; end
                  default: begin
                     if (tb < CH_SPACE) begin
                        b.chars[n]      = CH_BSLASH;
                        b.chars[n+4'd1] = 8'h75;
                        b.chars[n+4'd2] = CH_ZERO;
                        b.chars[n+4'd3] = CH_ZERO;
                        b.chars[n+4'd4] = hex_char(tb[7:4]);
                        b.chars[n+4'd5] = hex_char(tb[3:0]);
                        n = n + 4'd6;
                     end else begin
                        b.chars[n] = tb; n = n + 4'd1;
                     end
                  end
               endcase
            end
            if (last || empty) begin
               b.chars[n] = CH_QUOTE; n = n + 4'd1;
               if (kind == KIND_KEY) begin
                  b.chars[n] = CH_COLON; b.chars[n+4'd1] = CH_SPACE; n = n + 4'd2;
               end
            end
         end
         default: n = 4'd0;
      endcase
      b.len = n;
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/jsw_stream_if.sv]
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type comes from jsw_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface jsw_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/jsw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module jsw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

`default_nettype wire

[rtl/json_stream_writer.sv]
// JSON stream writer top level: sequencer, shift-add-3 converter, output register.
// Depends on jsw_pkg, jsw_stream_if and jsw_ram.
//
// Turns a stream of JSON events into pretty-printed text, one character per
// rsp transaction, out_last on the final character of each event. An event
// is taken only while the sequencer is idle; the output register lets the
// next event be taken while the last character still waits. A bracket
// or text event is accepted, looks up the container's first-value flag
// in the flag RAM where needed, then emits its characters (separator,
// newline, two spaces per level, body), holding while the output register
// is full. An integer event first runs the shift-add-3 unit (one magnitude
// bit per cycle) and strips leading zero digits one per cycle (up to 19),
// then emits its prefix, sign and digits. Nesting overflow on a begin and
// an end with nothing open produce one error transaction (character zero)
// and leave the nesting state alone. Kind 7 is dropped with no output. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module json_stream_writer
   import jsw_pkg::*;
#(
   parameter int MAX_DEPTH = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   jsw_stream_if.sink   req_chan,
   jsw_stream_if.source rsp_chan
);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CONV  = 4'd1;
   localparam logic [3:0] S_TRIM  = 4'd2;
   localparam logic [3:0] S_PREP  = 4'd3;
   localparam logic [3:0] S_FLAG  = 4'd4;
   localparam logic [3:0] S_COMMA = 4'd5;
   localparam logic [3:0] S_NL    = 4'd6;
   localparam logic [3:0] S_SP    = 4'd7;
   localparam logic [3:0] S_BODY  = 4'd8;
   localparam logic [3:0] S_SIGN  = 4'd9;
   localparam logic [3:0] S_DIG   = 4'd10;
   localparam logic [3:0] S_ERR   = 4'd11;

   // control state
   logic [3:0]    state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          after_key_ff, after_key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   // per-event working registers
   logic [2:0]    kind_ff, kind_in;
   logic          prep_ff, prep_in;
   logic          key_close_ff, key_close_in;
   logic          neg_ff, neg_in;
   logic          flag_ff, flag_in;
   body_type      body_ff, body_in;
   logic [3:0]    idx_ff, idx_in;
   logic [DW:0]   sp_ff, sp_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [4:0]    dig_ff, dig_in;
   logic [63:0]   mag_ff, mag_in;
   logic [79:0]   bcd_ff, bcd_in;
   // output register
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_error_ff, rsp_error_in;

   logic          req_fire, out_free, emit_req, emit_fire, emit_last, emit_err;
   logic [7:0]    emit_char;
   logic          is_end, is_begin, is_int;
   logic [3:0]    body_state;
   logic [DW-1:0] depth_m1;
   logic [79:0]   bcd_adj;
   logic [63:0]   raw;
   logic          ram_wr_en, ram_wr_data, ram_rd_en, ram_rd_data;
   logic [AW-1:0] ram_wr_addr;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit_fire = emit_req && out_free;
   assign is_end    = (kind_ff == KIND_END_OBJ) || (kind_ff == KIND_END_ARR);
   assign is_begin  = (kind_ff == KIND_BEGIN_OBJ) || (kind_ff == KIND_BEGIN_ARR);
   assign is_int    = (kind_ff == KIND_INT);
   assign depth_m1  = depth_ff - 1'b1;
   assign body_state = is_int ? (neg_ff ? S_SIGN : S_DIG) : S_BODY;
   assign raw       = req_chan.data.int_value;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = '{out_char: rsp_char_ff, out_last: rsp_last_ff,
                             out_error: rsp_error_ff};

   // Shift-add-3: correct every BCD digit of 5 or more before the shift.
   always_comb begin
      for (int d = 0; d < 20; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? (bcd_ff[d*4 +: 4] + 4'd3)
                                                        : bcd_ff[d*4 +: 4];
      end
   end

   // Character emitted in the current state, if any.
   always_comb begin
      emit_req  = 1'b0;
      emit_char = 8'd0;
      emit_last = 1'b0;
      emit_err  = 1'b0;
      unique case (state_ff)
         S_COMMA: begin emit_req = !is_end && !flag_ff; emit_char = CH_COMMA; end
         S_NL:    begin emit_req = 1'b1; emit_char = CH_NL; end
         S_SP:    begin emit_req = 1'b1; emit_char = CH_SPACE; end
         S_BODY: begin
            emit_req  = 1'b1;
            emit_char = body_ff.chars[idx_ff];
            emit_last = (idx_ff == body_ff.len - 4'd1);
         end
         S_SIGN:  begin emit_req = 1'b1; emit_char = CH_MINUS; end
         S_DIG: begin
            emit_req  = 1'b1;
            emit_char = CH_ZERO + {4'd0, bcd_ff[79:76]};
            emit_last = (dig_ff == 5'd1);
         end
         S_ERR:   begin emit_req = 1'b1; emit_last = 1'b1; emit_err = 1'b1; end
         default: emit_req = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      after_key_in = after_key_ff;
      kind_in      = kind_ff;
      prep_in      = prep_ff;
      key_close_in = key_close_ff;
      neg_in       = neg_ff;
      flag_in      = flag_ff;
      body_in      = body_ff;
      idx_in       = idx_ff;
      sp_in        = sp_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = depth_m1[AW-1:0];
      ram_wr_data  = 1'b0;
      ram_rd_en    = 1'b0;

      // output register: load on emit, drop valid once taken
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
         rsp_error_in = emit_err;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in      = req_chan.data.kind;
               body_in      = build_body(req_chan.data.kind, req_chan.data.text_byte,
                                         req_chan.data.text_first, req_chan.data.text_last,
                                         req_chan.data.text_empty);
               idx_in       = 4'd0;
               prep_in      = 1'b1;
               key_close_in = (req_chan.data.kind == KIND_KEY) &&
                              (req_chan.data.text_last || req_chan.data.text_empty);
               neg_in       = raw[63];
               mag_in       = raw[63] ? (~raw + 64'd1) : raw;
               bcd_in       = '0;
               cnt_in       = 6'd63;
               unique case (req_chan.data.kind) inside
                  KIND_BEGIN_OBJ, KIND_BEGIN_ARR:
                     state_in = (depth_ff >= DW'(MAX_DEPTH)) ? S_ERR : S_PREP;
                  KIND_END_OBJ, KIND_END_ARR:
                     state_in = (depth_ff == '0) ? S_ERR : S_PREP;
                  KIND_KEY, KIND_STRING: begin
                     prep_in  = req_chan.data.text_first || req_chan.data.text_empty;
                     state_in = S_PREP;
                  end
                  KIND_INT: state_in = S_CONV;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_CONV: begin
            bcd_in = {bcd_adj[78:0], mag_ff[63]};
            mag_in = {mag_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               dig_in   = 5'd20;
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            // strip one leading zero digit a cycle, keep at least one
            if (dig_ff > 5'd1 && bcd_ff[79:76] == 4'd0) begin
               bcd_in = {bcd_ff[75:0], 4'd0};
               dig_in = dig_ff - 5'd1;
            end else begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (is_end) begin
               ram_rd_en = 1'b1;
               state_in  = S_FLAG;
            end else if (!prep_ff) begin
               state_in = body_state;
            end else if (after_key_ff) begin
               after_key_in = 1'b0;
               state_in     = body_state;
            end else if (depth_ff == '0) begin
               state_in = body_state;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_FLAG;
            end
         end
         S_FLAG: begin
            flag_in = ram_rd_data;
            if (!is_end) begin
               ram_wr_en = 1'b1;  // container now holds a value
            end
            state_in = S_COMMA;
         end
         S_COMMA: begin
            sp_in = is_end ? {depth_m1, 1'b0} : {depth_ff, 1'b0};
            if (is_end && flag_ff) begin
               state_in = body_state;
            end else if (!emit_req || emit_fire) begin
               state_in = S_NL;
            end
         end
         S_NL: begin
            if (emit_fire) begin
               state_in = (sp_ff == '0) ? body_state : S_SP;
            end
         end
         S_SP: begin
            if (emit_fire) begin
               sp_in = sp_ff - 1'b1;
               if (sp_ff == (DW+1)'(1)) begin
                  state_in = body_state;
               end
            end
         end
         S_BODY: begin
            if (emit_fire) begin
               idx_in = idx_ff + 4'd1;
               if (emit_last) begin
                  state_in = S_IDLE;
                  if (is_begin) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = depth_ff[AW-1:0];
                     ram_wr_data = 1'b1;
                     depth_in    = depth_ff + 1'b1;
                  end
                  if (is_end) begin
                     depth_in = depth_m1;
                  end
                  if (key_close_ff) begin
                     after_key_in = 1'b1;
                  end
               end
            end
         end
         S_SIGN: begin
            if (emit_fire) begin
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            if (emit_fire) begin
               bcd_in = {bcd_ff[75:0], 4'd0};
               dig_in = dig_ff - 5'd1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (emit_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         after_key_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         after_key_ff <= after_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      prep_ff      <= prep_in;
      key_close_ff <= key_close_in;
      neg_ff       <= neg_in;
      flag_ff      <= flag_in;
      body_ff      <= body_in;
      idx_ff       <= idx_in;
      sp_ff        <= sp_in;
      cnt_ff       <= cnt_in;
      dig_ff       <= dig_in;
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   // first-value flag per open container
   jsw_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DEPTH),
      .AW    (AW)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (depth_m1[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // nesting never exceeds the configured limit
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_DEPTH))
      else $error("nesting depth above limit");

   // an error transaction is a single zero character closing its event
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_char_ff == 8'd0 && rsp_last_ff)
      else $error("malformed error transaction");

   // digit emission always has a digit left
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIG |-> dig_ff != 5'd0)
      else $error("digit counter ran out");

   // the depth moves only when an event finishes
   a_depth_change: assert property (@(posedge clock) disable iff (reset)
      depth_ff != $past(depth_ff) |-> $past(state_ff) == S_BODY && $past(emit_fire))
      else $error("depth changed outside event completion");

endmodule

`default_nettype wire

[verif/tb_json_stream_writer.sv]
// Self-checking testbench for json_stream_writer: drives JSON events, predicts
// the pretty-printed character stream and compares every rsp transaction.
// Depends on jsw_pkg, jsw_stream_if and the json_stream_writer RTL.
`timescale 1ns / 1ps

module tb_json_stream_writer
   import jsw_pkg::*;
();

   localparam int NEST_LIMIT = 16;
   localparam int CYCLE_LIMIT = 5000000;
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsw_stream_if #(.payload_type(req_payload_type)) req_chan ();
   jsw_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   json_stream_writer #(.MAX_DEPTH(NEST_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: mirrors the writer's nesting stack.
   logic       open_empty[NEST_LIMIT];
   logic [4:0] open_count;
   logic       key_pending;

   rsp_payload_type char_queue[$];
   int error_count = 0;
   int cycle_count = 0;
   int hold_off = 0;     // cycles the receiver must still stall
   int stall_left = 0;   // remaining cycles of a random long stall
   bit rsp_random = 1'b1;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
   end

   // Queue one character of the expected text.
   function automatic void push_char(input logic [7:0] c);
      rsp_payload_type r;
      r.out_char  = c;
      r.out_last  = 1'b0;
      r.out_error = 1'b0;
      char_queue = {char_queue, r};
   endfunction

   function automatic void push_indent(input int levels);
      push_char(CH_NL);
      for (int i = 0; i < 2 * levels; i++) push_char(CH_SPACE);
   endfunction

   // Comma, newline and indent ahead of a value, unless it follows a key.
   function automatic void push_separator();
      if (key_pending) begin
         key_pending = 1'b0;
         return;
      end
      if (open_count > 0) begin
         if (!open_empty[open_count-1]) push_char(CH_COMMA);
         open_empty[open_count-1] = 1'b0;
         push_indent(open_count);
      end
   endfunction

   function automatic void push_text_byte(input logic [7:0] b);
      case (b)
         8'h22: begin push_char(CH_BSLASH); push_char(8'h22); end
         8'h5c: begin push_char(CH_BSLASH); push_char(8'h5c); end
         8'h0a: begin push_char(CH_BSLASH); push_char("n"); end
         8'h0d: begin push_char(CH_BSLASH); push_char("r"); end
         8'h09: begin push_char(CH_BSLASH); push_char("t"); end
         8'h08: begin push_char(CH_BSLASH); push_char("b"); end
         8'h0c: begin push_char(CH_BSLASH); push_char("f"); end
         default: begin
            if (b < 8'h20) begin
               push_char(CH_BSLASH); push_char("u"); push_char("0"); push_char("0");
               push_char(8'h30 + {4'd0, b[7:4]});
               push_char(b[3:0] < 4'd10 ? 8'h30 + {4'd0, b[3:0]}
                                        : 8'h57 + {4'd0, b[3:0]});
            end else begin
               push_char(b);
            end
         end
      endcase
   endfunction

   function automatic void push_decimal(input logic [63:0] raw);
      logic [63:0] mag;
      logic [7:0]  digits[$];
      mag = raw;
      if (raw[63]) begin
         push_char(CH_MINUS);
         mag = ~raw + 64'd1;
      end
      do begin
         digits.push_front(CH_ZERO + 8'(mag % 64'd10));
         mag = mag / 64'd10;
      end while (mag != 0);
      foreach (digits[i]) push_char(digits[i]);
   endfunction

   // Work out the characters one event produces and append them.
   function automatic void predict_event(input req_payload_type ev);
      int start;
      rsp_payload_type e;
      start = char_queue.size();
      case (ev.kind)
         KIND_BEGIN_OBJ, KIND_BEGIN_ARR: begin
            if (open_count >= NEST_LIMIT) begin
               e.out_char = 8'h00; e.out_last = 1'b1; e.out_error = 1'b1;
               char_queue = {char_queue, e};
               return;
            end
            push_separator();
            push_char(ev.kind == KIND_BEGIN_OBJ ? CH_LBRACE : CH_LBRACK);
            open_empty[open_count] = 1'b1;
            open_count++;
         end
         KIND_END_OBJ, KIND_END_ARR: begin
            if (open_count == 0) begin
               e.out_char = 8'h00; e.out_last = 1'b1; e.out_error = 1'b1;
               char_queue = {char_queue, e};
               return;
            end
            open_count--;
            if (!open_empty[open_count]) push_indent(open_count);
            push_char(ev.kind == KIND_END_OBJ ? CH_RBRACE : CH_RBRACK);
         end
         KIND_KEY, KIND_STRING: begin
            if (ev.text_first || ev.text_empty) begin
               push_separator();
               push_char(CH_QUOTE);
            end
            if (!ev.text_empty) push_text_byte(ev.text_byte);
            if (ev.text_last || ev.text_empty) begin
               push_char(CH_QUOTE);
               if (ev.kind == KIND_KEY) begin
                  push_char(CH_COLON); push_char(CH_SPACE);
                  key_pending = 1'b1;
               end
            end
         end
         KIND_INT: begin
            push_separator();
            push_decimal(ev.int_value);
         end
         default: ;
      endcase
      if (char_queue.size() > start) char_queue[$].out_last = 1'b1;
   endfunction

   // Receiver: random stalls, occasional long ones, plus an optional hold-off.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!rsp_random) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 59) == 0) begin
         stall_left <= $urandom_range(10, 40);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 9) < 8);
      end
   end

   // Check each accepted character against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (char_queue.size() == 0) begin
            $display("%0t: unexpected rsp %h", $time, rsp_chan.data);
            error_count++;
         end else begin
            rsp_payload_type e;
            e = char_queue.pop_front();
            if (rsp_chan.data.out_char !== e.out_char) begin
               $display("%0t: out_char exp %h got %h", $time, e.out_char,
                        rsp_chan.data.out_char);
               error_count++;
            end
            if (rsp_chan.data.out_last !== e.out_last) begin
               $display("%0t: out_last exp %b got %b", $time, e.out_last,
                        rsp_chan.data.out_last);
               error_count++;
            end
            if (rsp_chan.data.out_error !== e.out_error) begin
               $display("%0t: out_error exp %b got %b", $time, e.out_error,
                        rsp_chan.data.out_error);
               error_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one event, wait for the transaction, then predict its output.
   task automatic send_event(input req_payload_type ev, input bit gaps = 1'b1);
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
               $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
         repeat (gap) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= ev;
      // ready is stable between edges: sample it mid-cycle
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      predict_event(ev);
   endtask

   function automatic req_payload_type make_event(input logic [2:0] kind);
      req_payload_type ev;
      ev.kind       = kind;
      ev.text_byte  = 8'($urandom);
      ev.text_first = 1'b0;
      ev.text_last  = 1'b0;
      ev.text_empty = 1'b0;
      ev.int_value  = {$urandom, $urandom};
      return ev;
   endfunction

   task automatic send_text(input logic [2:0] kind, input int len);
      req_payload_type ev;
      if (len == 0) begin
         ev = make_event(kind);
         ev.text_empty = 1'b1;
         send_event(ev);
         return;
      end
      for (int i = 0; i < len; i++) begin
         ev = make_event(kind);
         if ($urandom_range(0, 3) == 0) ev.text_byte = 8'($urandom_range(0, 8'h22));
         ev.text_first = (i == 0);
         ev.text_last  = (i == len - 1);
         send_event(ev);
      end
   endtask

   task automatic send_int(input logic [63:0] v, input bit gaps = 1'b1);
      req_payload_type ev;
      ev = make_event(KIND_INT);
      ev.int_value = v;
      send_event(ev, gaps);
   endtask

   // Hold the sender until the writer has drained everything.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (char_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic test_directed();
      req_payload_type ev;
      // Underflow with nothing open, then a dropped kind.
      send_event(make_event(KIND_END_OBJ));
      send_event(make_event(KIND_END_ARR));
      send_event(make_event(KIND_UNUSED));
      send_event(make_event(KIND_BEGIN_OBJ));
      send_event(make_event(KIND_END_OBJ));          // empty object
      send_event(make_event(KIND_BEGIN_ARR));
      send_int(64'h8000_0000_0000_0000);             // integer minimum
      send_int(64'h7fff_ffff_ffff_ffff);
      send_int(64'd0);
      send_int(64'hffff_ffff_ffff_ffff);
      send_text(KIND_STRING, 0);                     // empty string
      ev = make_event(KIND_STRING); ev.text_first = 1'b1; ev.text_byte = 8'h22;
      send_event(ev);
      ev = make_event(KIND_STRING); ev.text_byte = 8'h5c; send_event(ev);
      ev = make_event(KIND_STRING); ev.text_byte = 8'h1f; send_event(ev);
      ev = make_event(KIND_STRING); ev.text_byte = 8'hff; ev.text_last = 1'b1;
      send_event(ev);
      send_event(make_event(KIND_BEGIN_OBJ));
      send_text(KIND_KEY, 0);                        // empty key
      send_event(make_event(KIND_END_ARR));          // mismatched close after key
      send_event(make_event(KIND_END_OBJ));
   endtask

   // Every short escape, plus bytes 00 and 7f, each as a one-byte string.
   task automatic test_escapes();
      req_payload_type ev;
      logic [7:0] specials[9] = '{8'h22, 8'h5c, 8'h0a, 8'h0d, 8'h09, 8'h08, 8'h0c,
                                  8'h00, 8'h7f};
      foreach (specials[i]) begin
         ev = make_event(KIND_STRING);
         ev.text_byte = specials[i];
         ev.text_first = 1'b1;
         ev.text_last = 1'b1;
         send_event(ev);
      end
   endtask

   task automatic test_overflow();
      for (int i = open_count; i < NEST_LIMIT; i++)
         send_event(make_event($urandom_range(0, 1) ? KIND_BEGIN_OBJ : KIND_BEGIN_ARR));
      send_event(make_event(KIND_BEGIN_ARR));        // nesting overflow
      send_event(make_event(KIND_BEGIN_OBJ));
      while (open_count > 0)
         send_event(make_event($urandom_range(0, 1) ? KIND_END_OBJ : KIND_END_ARR));
      send_event(make_event(KIND_END_OBJ));
   endtask

   // Stall the receiver for a long stretch while the sender keeps going.
   task automatic test_backpressure();
      hold_off <= 400;
      send_event(make_event(KIND_BEGIN_ARR), 1'b0);
      for (int i = 0; i < 6; i++) send_int({$urandom, $urandom});
      send_event(make_event(KIND_END_ARR), 1'b0);
      drain();
   endtask

   // Mostly well-formed documents with random content, some noise.
   task automatic test_random(input int target);
      int sent;
      req_payload_type ev;
      sent = 0;
      while (sent < target) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 15 && open_count < NEST_LIMIT) begin
            send_event(make_event($urandom_range(0, 1) ? KIND_BEGIN_OBJ : KIND_BEGIN_ARR));
            if ($urandom_range(0, 1)) begin
               send_text(KIND_KEY, $urandom_range(0, 3));
               sent += 2;
            end
            sent++;
         end else if (pick < 30) begin
            send_event(make_event($urandom_range(0, 1) ? KIND_END_OBJ : KIND_END_ARR));
            sent++;
         end else if (pick < 50) begin
            send_text(KIND_STRING, $urandom_range(0, 4));
            sent += 2;
         end else if (pick < 62) begin
            send_text(KIND_KEY, $urandom_range(0, 3));
            sent += 2;
         end else if (pick < 85) begin
            send_int($urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 99))
                                                : {$urandom, $urandom});
            sent++;
         end else begin
            ev = make_event(3'($urandom_range(4, 7)));  // broken framing and kind 7
            ev.text_first = 1'($urandom);
            ev.text_last  = 1'($urandom);
            ev.text_empty = ($urandom_range(0, 7) == 0);
            send_event(ev);
            sent++;
         end
         if (pick == 99) begin
            rsp_random = 1'b0;                      // stretch with no stalls
            for (int i = 0; i < 8; i++) send_int({$urandom, $urandom}, 1'b0);
            rsp_random = 1'b1;
            sent += 8;
         end
      end
   endtask

   initial begin
      open_count  = '0;
      key_pending = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_escapes();
      test_overflow();
      drain();
      test_backpressure();
      test_random(235);
      drain();
      if (error_count == 0 && char_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
